### rtl/core/afl_pkg.sv
`timescale 1ns / 1ps

package afl_pkg;

  localparam int BUFFER_FRAMES = 65536;
  localparam int CHANNELS      = 2;
  localparam int SINE_ENTRIES  = 1024;

  localparam int SAMPLE_W  = 16;
  localparam int CH_W      = 3;
  localparam int CNT_CFG_W = 4;
  localparam int DELAY_W   = 16;
  localparam int PHASE_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int FRAME_W   = $clog2(BUFFER_FRAMES);
  localparam int MEM_DEPTH = BUFFER_FRAMES * CHANNELS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int SW        = $clog2(SINE_ENTRIES);
  localparam int QUARTER   = SINE_ENTRIES / 4;
  localparam int QW        = $clog2(QUARTER);
  localparam int MAG_W     = 15;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [PHASE_W-1:0]   PHASE_STEP_RESET = 32'd89478;
  localparam logic [CNT_CFG_W-1:0] CHANNELS_RESET   = 4'd2;

  localparam longint Q30_ONE      = 64'sd1073741824;
  localparam longint Q30_ONE_HALF = Q30_ONE / 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_DELAY = 2'd0,
    REG_DEPTH      = 2'd1,
    REG_PHASE_STEP = 2'd2,
    REG_CHANNELS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DELAY_W-1:0]   base_delay;
    logic [DELAY_W-1:0]   depth_amount;
    logic [PHASE_W-1:0]   phase_step;
    logic [CNT_CFG_W-1:0] channels_in_use;
  } afl_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]            ch;
    logic                       has_mem;
    logic [FRAME_W-1:0]         wp;
    logic [SW-1:0]              k;
  } afl_item_t;

  // Magnitude of the Q15 sine for a quarter-wave position tidx, where tidx
  // equal to QUARTER is the peak of the wave.
  function automatic logic [MAG_W-1:0] sine_mag(input longint tidx);
    longint t;
    longint u;
    longint acc;
    longint s;
    longint v;
    t   = tidx <<< (32 - SW);
    u   = (t * t) / Q30_ONE;
    acc = 64'sd172274;
    acc = -64'sd5026996 + (acc * u) / Q30_ONE;
    acc = 64'sd85569306 + (acc * u) / Q30_ONE;
    acc = -64'sd693598668 + (acc * u) / Q30_ONE;
    acc = 64'sd1686629713 + (acc * u) / Q30_ONE;
    s   = (t * acc) / Q30_ONE;
    if (s < 0) begin
      s = 0;
    end
    v = (s * 32767 + Q30_ONE_HALF) / Q30_ONE;
    if (v > 32767) begin
      v = 32767;
    end
    return MAG_W'(v);
  endfunction

  typedef logic [QUARTER-1:0][MAG_W-1:0] sine_tab_t;

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int i = 0; i < QUARTER; i++) begin
      tab[i] = sine_mag(longint'(i));
    end
    return tab;
  endfunction

  localparam sine_tab_t        SINE_TAB  = build_sine_tab();
  localparam logic [MAG_W-1:0] SINE_PEAK = sine_mag(longint'(QUARTER));

endpackage

### rtl/core/afl_ram.sv
`timescale 1ns / 1ps

module afl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

### rtl/core/afl_front.sv
`timescale 1ns / 1ps

module afl_front
  import afl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  afl_cfg_t            cfg,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,
  input  logic [CH_W-1:0]     s_tuser,
  input  logic                room,
  output logic                push,
  output afl_item_t           item
);

  logic [FRAME_W-1:0]   wp;
  logic [PHASE_W-1:0]   phase;
  logic [CNT_CFG_W-1:0] eff;
  logic                 last;

  always_comb begin
    if (cfg.channels_in_use == '0) begin
      eff = CNT_CFG_W'(1);
    end else if (cfg.channels_in_use > CNT_CFG_W'(CHANNELS)) begin
      eff = CNT_CFG_W'(CHANNELS);
    end else begin
      eff = cfg.channels_in_use;
    end
  end

  assign last     = (CNT_CFG_W'(s_tuser) == eff - CNT_CFG_W'(1));
  assign s_tready = room;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    item.sample  = s_tdata;
    item.ch      = s_tuser;
    item.has_mem = (CNT_CFG_W'(s_tuser) < CNT_CFG_W'(CHANNELS));
    item.wp      = wp;
    item.k       = phase[PHASE_W-1 -: SW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      phase <= '0;
    end else if (push && last) begin
      wp    <= wp + FRAME_W'(1);
      phase <= phase + cfg.phase_step;
    end
  end

endmodule

### rtl/core/afl_fifo.sv
`timescale 1ns / 1ps

module afl_fifo
  import afl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  afl_item_t push_item,
  input  logic      pop,
  output afl_item_t pop_item,
  output logic      valid,
  output logic      full
);

  localparam int CNT_W = PTR_W + 1;

  afl_item_t          entries [FIFO_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;

  assign valid    = (count != '0);
  assign full     = (count == CNT_W'(FIFO_DEPTH));
  assign pop_item = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("Queue written while full.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("Queue read while empty.");

endmodule

### rtl/core/afl_back.sv
`timescale 1ns / 1ps

module afl_back
  import afl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  afl_cfg_t            cfg,
  input  logic                fifo_valid,
  input  afl_item_t           fifo_item,
  output logic                pop,
  output logic                clearing,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,
  output logic [CH_W-1:0]     m_tuser
);

  logic adv;

  logic                 v1;
  afl_item_t            it1;
  logic [MAG_W-1:0]     mag1;
  logic                 neg1;

  logic                 v2;
  afl_item_t            it2;
  logic [31:0]          prod2;

  logic                 v3;
  afl_item_t            it3;
  logic [ADDR_W-1:0]    waddr3;
  logic [ADDR_W-1:0]    raddr3;
  logic                 byp3;

  logic                         v4;
  logic signed [SAMPLE_W-1:0]   sample4;
  logic [CH_W-1:0]              ch4;
  logic                         mem4;
  logic                         byp4;

  logic [ADDR_W-1:0]    clr_addr;

  logic [1:0]           quad;
  logic [QW-1:0]        j;
  logic [QW-1:0]        tj;
  logic [MAG_W-1:0]     mag;

  logic [15:0]          factor;
  logic [15:0]          q0;
  logic [17:0]          rem0;
  logic [16:0]          quo;
  logic [16:0]          dsum;
  logic [FRAME_W-1:0]   dly;
  logic [FRAME_W-1:0]   rframe;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [SAMPLE_W-1:0]   ram_wdata;
  logic [SAMPLE_W-1:0]   ram_rdata;

  logic signed [SAMPLE_W-1:0] old;
  logic signed [SAMPLE_W:0]   sum;
  logic [SAMPLE_W-1:0]        sat;

  assign adv = !m_tvalid || m_tready;
  assign pop = adv && fifo_valid && !clearing;

  // Quarter-wave sine lookup.
  always_comb begin
    quad = fifo_item.k[SW-1 -: 2];
    j    = fifo_item.k[QW-1:0];
    tj   = quad[0] ? (QW'(0) - j) : j;
    if (quad[0] && (j == '0)) begin
      mag = SINE_PEAK;
    end else begin
      mag = SINE_TAB[tj];
    end
  end

  assign factor = neg1 ? (16'd32767 - 16'(mag1)) : (16'd32767 + 16'(mag1));

  // Division by 65534: the quotient is the high half plus a correction of 0 to 2.
  always_comb begin
    q0   = prod2[31:16];
    rem0 = 18'(prod2[15:0]) + {1'b0, q0, 1'b0};
    quo  = 17'(q0) + 17'(rem0 >= 18'd65534) + 17'(rem0 >= 18'd131068);
    dsum = 17'(cfg.base_delay) + 17'(quo[15:0]);
    dly  = dsum[FRAME_W-1:0];
    rframe = it2.wp - dly;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= pop;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      m_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1     <= fifo_item;
      mag1    <= mag;
      neg1    <= quad[1];
      it2     <= it1;
      prod2   <= 32'(cfg.depth_amount) * 32'(factor);
      it3     <= it2;
      waddr3  <= ADDR_W'(it2.wp) * ADDR_W'(CHANNELS) + ADDR_W'(it2.ch);
      raddr3  <= ADDR_W'(rframe) * ADDR_W'(CHANNELS) + ADDR_W'(it2.ch);
      byp3    <= (dly == '0);
      sample4 <= it3.sample;
      ch4     <= it3.ch;
      mem4    <= it3.has_mem;
      byp4    <= byp3;
      m_tdata <= sat;
      m_tuser <= ch4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = adv && v3 && it3.has_mem;
      ram_waddr = waddr3;
      ram_wdata = it3.sample;
    end
  end

  afl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (raddr3),
    .rdata (ram_rdata)
  );

  // With zero delay the read hits the word stored in the same cycle.
  always_comb begin
    if (!mem4) begin
      old = '0;
    end else if (byp4) begin
      old = sample4;
    end else begin
      old = ram_rdata;
    end
    sum = {sample4[SAMPLE_W-1], sample4} + {old[SAMPLE_W-1], old};
    if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
      sat = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sat = sum[SAMPLE_W-1:0];
    end
  end

  a_idle_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(v1 || v2 || v3 || v4 || m_tvalid))
    else $error("Pipeline busy during memory clear.");
  a_bypass_same_word: assert property (@(posedge clk) disable iff (rst)
    v3 && it3.has_mem && byp3 |-> raddr3 == waddr3)
    else $error("Bypass taken for a different word.");
  a_clear_complete: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> clr_addr == '0)
    else $error("Memory clear ended early.");

endmodule

### rtl/core/audio_flanger.sv
`timescale 1ns / 1ps

// Flanger: each word carries one signed 16-bit sample with its channel in
// tuser, and yields one word with the sample plus a delayed sample of the same
// channel (zero for a channel beyond CHANNELS - 1), saturated. The block
// sustains one word per clock while the output is not stalled: the delay
// memory takes at most one write and one read per cycle, and the sine, the
// depth multiply and the delay arithmetic each sit in a stage of their own. A
// four-word queue separates input acceptance from the pipeline. After reset
// the delay memory is cleared one word per cycle, all BUFFER_FRAMES * CHANNELS
// (131072) words; s_tready stays low meanwhile, and configuration writes are
// taken at any time. Configuration should change only while no word is in
// flight.
module audio_flanger
  import afl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_in
  input  logic [CH_W-1:0]       s_tuser,   // [2:0] channel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample_out
  output logic [CH_W-1:0]       m_tuser,   // [2:0] channel_out
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  afl_cfg_t  cfg;
  afl_item_t push_item;
  afl_item_t pop_item;
  logic      push;
  logic      pop;
  logic      fifo_valid;
  logic      fifo_full;
  logic      clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_delay      <= '0;
      cfg.depth_amount    <= '0;
      cfg.phase_step      <= PHASE_STEP_RESET;
      cfg.channels_in_use <= CHANNELS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_DELAY: cfg.base_delay      <= cfg_data[DELAY_W-1:0];
        REG_DEPTH:      cfg.depth_amount    <= cfg_data[DELAY_W-1:0];
        REG_PHASE_STEP: cfg.phase_step      <= cfg_data[PHASE_W-1:0];
        REG_CHANNELS:   cfg.channels_in_use <= cfg_data[CNT_CFG_W-1:0];
        default:        cfg.base_delay      <= cfg.base_delay;
      endcase
    end
  end

  afl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .room     (!fifo_full && !clearing),
    .push     (push),
    .item     (push_item)
  );

  afl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .valid     (fifo_valid),
    .full      (fifo_full)
  );

  afl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fifo_valid (fifo_valid),
    .fifo_item  (pop_item),
    .pop        (pop),
    .clearing   (clearing),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import afl_pkg::*;

  localparam longint Q30    = 64'sd1073741824;
  localparam longint SIN_C1 = 64'sd1686629713;
  localparam longint SIN_C3 = 64'sd693598668;
  localparam longint SIN_C5 = 64'sd85569306;
  localparam longint SIN_C7 = 64'sd5026996;
  localparam longint SIN_C9 = 64'sd172274;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]     ch;
  } flanged_word_t;

  class flanger_checker;
    logic [SAMPLE_W-1:0]  delay_mem [MEM_DEPTH];
    int unsigned          frame_pos;
    logic [PHASE_W-1:0]   lfo_phase;
    logic [DELAY_W-1:0]   base_delay;
    logic [DELAY_W-1:0]   depth_amount;
    logic [PHASE_W-1:0]   phase_step;
    logic [CNT_CFG_W-1:0] chan_count;
    flanged_word_t        pending_sums [$];
    int                   errors;
    int                   words_checked;

    function new();
      foreach (delay_mem[i]) delay_mem[i] = '0;
      frame_pos     = 0;
      lfo_phase     = '0;
      base_delay    = '0;
      depth_amount  = '0;
      phase_step    = PHASE_STEP_RESET;
      chan_count    = CHANNELS_RESET;
      errors        = 0;
      words_checked = 0;
    endfunction

    function int lfo_sine(logic [PHASE_W-1:0] phase);
      longint k;
      longint a;
      longint r;
      longint t;
      longint u;
      longint acc;
      longint s;
      longint v;
      int quad;
      k    = (longint'(phase) * SINE_ENTRIES) >> 32;
      a    = (k << 32) / SINE_ENTRIES;
      quad = int'((a >> 30) & 3);
      r    = a & (Q30 - 1);
      t    = ((quad & 1) != 0) ? (Q30 - r) : r;
      u    = (t * t) / Q30;
      acc  = SIN_C9;
      acc  = -SIN_C7 + (acc * u) / Q30;
      acc  = SIN_C5 + (acc * u) / Q30;
      acc  = -SIN_C3 + (acc * u) / Q30;
      acc  = SIN_C1 + (acc * u) / Q30;
      s    = (t * acc) / Q30;
      if (s < 0) s = 0;
      v = (s * 32767 + Q30 / 2) / Q30;
      if (v > 32767) v = 32767;
      return ((quad & 2) != 0) ? -int'(v) : int'(v);
    endfunction

    function int eff_channels();
      if (chan_count == 0) return 1;
      if (chan_count > CHANNELS) return CHANNELS;
      return int'(chan_count);
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void note_sample(logic [SAMPLE_W-1:0] din, logic [CH_W-1:0] ch);
      int s;
      longint modv;
      int unsigned d;
      int unsigned rd;
      logic signed [SAMPLE_W-1:0] old;
      int sum;
      flanged_word_t w;
      s    = lfo_sine(lfo_phase);
      modv = (longint'(depth_amount) * (32767 + s)) / 65534;
      d    = int'((longint'(base_delay) + modv) % BUFFER_FRAMES);
      rd   = (frame_pos + BUFFER_FRAMES - d) % BUFFER_FRAMES;
      old  = '0;
      if (ch < CHANNELS) begin
        delay_mem[frame_pos * CHANNELS + ch] = din;
        old = delay_mem[rd * CHANNELS + ch];
      end
      sum = int'($signed(din)) + int'(old);
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      w.sample = sum[SAMPLE_W-1:0];
      w.ch     = ch;
      pending_sums.push_back(w);
      if (int'(ch) == eff_channels() - 1) begin
        frame_pos = (frame_pos + 1) % BUFFER_FRAMES;
        lfo_phase = lfo_phase + phase_step;
      end
    endfunction

    task check_sum(logic [SAMPLE_W-1:0] dout, logic [CH_W-1:0] ch);
      flanged_word_t want;
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected word, sample %h channel %0d", dout, ch));
        return;
      end
      want = pending_sums.pop_front();
      words_checked++;
      if (dout !== want.sample)
        report_mismatch($sformatf("word %0d sample %h, expected %h",
                                  words_checked, dout, want.sample));
      if (ch !== want.ch)
        report_mismatch($sformatf("word %0d channel %0d, expected %0d",
                                  words_checked, ch, want.ch));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;   // [15:0] sample_in
  logic [CH_W-1:0]       s_tuser = '0;   // [2:0] channel
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;        // [15:0] sample_out
  logic [CH_W-1:0]       m_tuser;        // [2:0] channel_out
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BASE_DELAY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  flanger_checker sb;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int words_sent = 0;
  int configs_run = 0;

  audio_flanger dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h7FFF;
    if (r < 16) return 16'h8000;
    if (r < 24) return 16'($urandom_range(0, 15)) - 16'd8;
    if (r < 40) return {1'b0, 15'($urandom)} ^ {16{$urandom_range(0, 1) == 1}};
    return 16'($urandom);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tdata, s_tuser);
      if (m_tvalid && m_tready) sb.check_sum(m_tdata, m_tuser);
    end
  end

  initial begin
    int rx_hold;
    rx_hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_hold = 400;
      end
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_tready <= 1'b1;
        if (!rx_quiet && $urandom_range(0, 99) < 20) rx_hold = pick_gap();
      end
    end
  end

  task automatic send_word(logic [SAMPLE_W-1:0] smp, logic [CH_W-1:0] ch);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_config(logic [DELAY_W-1:0] base, logic [DELAY_W-1:0] depth,
                            logic [PHASE_W-1:0] step, logic [CNT_CFG_W-1:0] chans);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BASE_DELAY;
    cfg_data  <= {16'($urandom), base};
    @(posedge clk);
    cfg_index <= REG_DEPTH;
    cfg_data  <= {16'($urandom), depth};
    @(posedge clk);
    cfg_index <= REG_PHASE_STEP;
    cfg_data  <= step;
    @(posedge clk);
    cfg_index <= REG_CHANNELS;
    cfg_data  <= {28'($urandom), chans};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.base_delay   = base;
    sb.depth_amount = depth;
    sb.phase_step   = step;
    sb.chan_count   = chans;
    configs_run++;
  endtask

  // Mostly complete frames in channel order, with stray channels mixed in.
  task automatic run_frames(int n_items);
    int sent;
    int eff;
    sent = 0;
    eff  = sb.eff_channels();
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        for (int c = 0; c < eff; c++) send_word(pick_sample(), CH_W'(c));
        sent += eff;
      end else begin
        send_word(pick_sample(), CH_W'($urandom_range(0, 7)));
        sent++;
      end
    end
  endtask

  task automatic run_phase(logic [DELAY_W-1:0] base, logic [DELAY_W-1:0] depth,
                           logic [PHASE_W-1:0] step, logic [CNT_CFG_W-1:0] chans,
                           bit quiet, bit hold);
    wait_drained();
    set_config(base, depth, step, chans);
    tx_quiet = quiet;
    rx_quiet = quiet;
    if (hold) long_hold_req = 1'b1;
    run_frames(170);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings give a zero delay, so each result on channels 0 and 1 is the doubled input, saturated.
    send_word(16'h7FFF, 3'd0);
    send_word(16'h7FFF, 3'd1);
    send_word(16'h8000, 3'd0);
    send_word(16'h8000, 3'd1);
    send_word(16'h0000, 3'd0);
    send_word(16'h0000, 3'd1);
    send_word(16'h0001, 3'd0);
    send_word(16'hFFFF, 3'd1);
    send_word(16'h4000, 3'd0);
    send_word(16'h3FFF, 3'd1);
    send_word(16'hBFFF, 3'd0);
    send_word(16'hC000, 3'd1);
    send_word(16'h1234, 3'd7);
    send_word(16'h8000, 3'd5);
    send_word(16'h7FFF, 3'd2);
    send_word(16'h0055, 3'd1);
    send_word(16'h0AAA, 3'd0);
    send_word(16'h5555, 3'd3);
    send_word(16'hAAAA, 3'd4);
    send_word(16'h0101, 3'd6);

    run_phase(16'd1, 16'd0, 32'd0, 4'd2, 1'b0, 1'b0);
    run_phase(16'd3, 16'd20, 32'h0400_0000, 4'd2, 1'b1, 1'b0);
    run_phase(16'd0, 16'hFFFF, 32'h0100_0000, 4'd2, 1'b0, 1'b0);
    run_phase(16'hFFFF, 16'd12, 32'h1234_5678, 4'd2, 1'b0, 1'b0);
    run_phase(16'd10, 16'd40, 32'hFFFF_FFFF, 4'd1, 1'b0, 1'b0);
    run_phase(16'd5, 16'd30, 32'($urandom), 4'd0, 1'b0, 1'b0);
    run_phase(16'd2, 16'd8, 32'h0800_0000, 4'd15, 1'b0, 1'b1);
    run_phase(16'hFFFF, 16'hFFFF, 32'($urandom), 4'd8, 1'b0, 1'b0);
    run_phase(16'($urandom_range(0, 40)), 16'($urandom_range(0, 60)), 32'($urandom),
              4'($urandom_range(0, 15)), 1'b0, 1'b0);
    run_phase(16'd0, 16'd6, 32'h4000_0000, 4'd2, 1'b0, 1'b0);

    s_tvalid <= 1'b0;
    wait_drained();
    if (sb.pending_sums.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_sums.size()));
    $display("Sent %0d words under %0d register settings, checked %0d results.",
             words_sent, configs_run + 1, sb.words_checked);
    $display("Settings spanned zero, wrapped and full-depth delays and channel counts 0 to 15.");
    if (sb.errors == 0) begin
      $display("audio_flanger verification clean");
    end else begin
      $display("audio_flanger verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", sb.pending_sums.size());
    $display("audio_flanger verification failed");
    $finish;
  end

endmodule
